// File: hdl/prqa_pkg.sv
// ---------------------------------------------------------------------------
// Priority request queue admission package
// Types and codes shared by the queue sequencer and its users.
// ---------------------------------------------------------------------------
package prqa_pkg;

  localparam logic [2:0] CMD_SUBMIT      = 3'd0;
  localparam logic [2:0] CMD_CANCEL_FILE = 3'd1;
  localparam logic [2:0] CMD_CANCEL_BELOW = 3'd2;
  localparam logic [2:0] CMD_CANCEL_ALL  = 3'd3;
  localparam logic [2:0] CMD_POP         = 3'd4;

  localparam logic [2:0] RES_ACCEPTED    = 3'd0;
  localparam logic [2:0] RES_REFUSED     = 3'd1;
  localparam logic [2:0] RES_DROPPED     = 3'd2;
  localparam logic [2:0] RES_DISPATCHED  = 3'd3;
  localparam logic [2:0] RES_EMPTY       = 3'd4;
  localparam logic [2:0] RES_CANCEL_DONE = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] file_id;
    logic [31:0] frame_number;
    logic [7:0]  priority_req;
    logic        is_visible;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] tag;
    logic [15:0] out_file_id;
    logic [31:0] out_frame_number;
    logic [7:0]  out_priority;
    logic        out_is_visible;
    logic [5:0]  queue_count;
    logic        last;
  } out_item_t;

  // One queue slot as held in the memory.
  typedef struct packed {
    logic [15:0] file_id;
    logic [31:0] frame_number;
    logic [31:0] tag;
    logic [7:0]  prio;
    logic        is_visible;
  } entry_t;

endpackage

// File: hdl/prqa_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module prqa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/priority_request_queue_admission.sv
// ---------------------------------------------------------------------------
// Priority request queue admission
// Bounded request queue in descending priority order with admission rules.
// ---------------------------------------------------------------------------
// The queue lives in one simple dual-port RAM split into two banks; every
// command on a non-empty queue streams the live bank into the other one,
// one entry per cycle while the output does not stall, dropping and
// inserting on the way, and then swaps banks. A submit first walks the
// queue from the tail to report superseded entries and to find an eviction
// victim, then makes the compacting pass. Every reported result that meets
// a busy output holds the walk for as long as the output stalls. The input
// is taken only between commands. The single configuration register, the
// visible reserve, may be written at any time the block is idle and is
// always ready. No clearing pass is needed after reset: only entries below
// the live count are ever used.
// ---------------------------------------------------------------------------
module priority_request_queue_admission #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prqa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prqa_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);

  import prqa_pkg::*;

  localparam int IW       = $clog2(QUEUE_DEPTH);
  localparam int CW       = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = 2 * (1 << IW);
  localparam int MAX_RES  = QUEUE_DEPTH - 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_COPY   = 3'd3;
  localparam logic [2:0] ST_TAIL   = 3'd4;
  localparam logic [2:0] ST_FINAL  = 3'd5;

  // Control and payload registers.
  logic [2:0]    state_r, state_nxt;
  in_item_t      req_r, req_nxt;
  logic [31:0]   tag_r, tag_nxt;
  logic [31:0]   next_tag_r, next_tag_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          bank_r, bank_nxt;
  logic [IW-1:0] ridx_r, ridx_nxt;
  logic [CW-1:0] widx_r, widx_nxt;
  logic          ins_done_r, ins_done_nxt;
  logic          accept_r, accept_nxt;
  logic          evict_on_r, evict_on_nxt;
  logic          evict_found_r, evict_found_nxt;
  logic [IW-1:0] evict_idx_r, evict_idx_nxt;
  entry_t        evict_ent_r, evict_ent_nxt;
  entry_t        pop_ent_r, pop_ent_nxt;
  logic [4:0]    reserve_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  // Memory ports.
  logic          ram_we;
  logic [IW:0]   ram_waddr;
  entry_t        ram_wdata;
  logic [IW:0]   ram_raddr;
  entry_t        ram_rdata;
  logic [IW-1:0] rd_idx;

  prqa_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry built from the request being submitted.
  entry_t req_ent;
  assign req_ent = '{file_id: req_r.file_id, frame_number: req_r.frame_number,
                     tag: tag_r, prio: req_r.priority_req,
                     is_visible: req_r.is_visible};

  // Tests of the entry whose data is on the read port against the request.
  logic superseded, beaten, cancel_hit, kill;
  logic last_src;
  logic can_emit;
  logic [5:0] res_cl, limit;

  assign superseded = (ram_rdata.file_id == req_r.file_id) &&
                      (ram_rdata.frame_number < req_r.frame_number) &&
                      (ram_rdata.prio <= req_r.priority_req) &&
                      !(ram_rdata.is_visible && !req_r.is_visible);
  assign beaten = (req_r.is_visible && !ram_rdata.is_visible) ||
                  (ram_rdata.prio < req_r.priority_req);

  always_comb begin
    case (req_r.cmd)
      CMD_CANCEL_FILE:  cancel_hit = (ram_rdata.file_id == req_r.file_id);
      CMD_CANCEL_BELOW: cancel_hit = (ram_rdata.file_id == req_r.file_id) &&
                                     (ram_rdata.frame_number < req_r.frame_number);
      CMD_CANCEL_ALL:   cancel_hit = 1'b1;
      default:          cancel_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (req_r.cmd)
      CMD_SUBMIT: kill = superseded || (evict_on_r && (ridx_r == evict_idx_r));
      CMD_POP:    kill = (ridx_r == '0);
      default:    kill = cancel_hit;
    endcase
  end

  assign last_src = (CW'(ridx_r) == (len_r - 1'b1));
  assign can_emit = !out_valid_r || out_ready;

  // The non-visible limit is the depth less the clamped reserve.
  assign res_cl = (6'(reserve_r) > 6'(MAX_RES)) ? 6'(MAX_RES) : 6'(reserve_r);
  assign limit  = 6'(QUEUE_DEPTH) - res_cl;

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    tag_nxt         = tag_r;
    next_tag_nxt    = next_tag_r;
    cnt_nxt         = cnt_r;
    len_nxt         = len_r;
    bank_nxt        = bank_r;
    ridx_nxt        = ridx_r;
    widx_nxt        = widx_r;
    ins_done_nxt    = ins_done_r;
    accept_nxt      = accept_r;
    evict_on_nxt    = evict_on_r;
    evict_found_nxt = evict_found_r;
    evict_idx_nxt   = evict_idx_r;
    evict_ent_nxt   = evict_ent_r;
    pop_ent_nxt     = pop_ent_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_nxt         = out_r;
    rd_idx          = ridx_r;
    ram_we          = 1'b0;
    ram_waddr       = {!bank_r, widx_r[IW-1:0]};
    ram_wdata       = ram_rdata;

    case (state_r)
      ST_IDLE: begin
        rd_idx = (in_data.cmd == CMD_SUBMIT) ? IW'(cnt_r - 1'b1) : '0;
        if (in_valid) begin
          req_nxt         = in_data;
          len_nxt         = cnt_r;
          widx_nxt        = '0;
          ins_done_nxt    = 1'b0;
          accept_nxt      = 1'b0;
          evict_on_nxt    = 1'b0;
          evict_found_nxt = 1'b0;
          ridx_nxt        = rd_idx;
          if (in_data.cmd == CMD_SUBMIT) begin
            tag_nxt      = next_tag_r;
            next_tag_nxt = (next_tag_r == 32'hFFFF_FFFF) ? 32'd1 : next_tag_r + 32'd1;
            state_nxt    = (cnt_r != '0) ? ST_SCAN : ST_DECIDE;
          end else if (in_data.cmd == CMD_CANCEL_FILE || in_data.cmd == CMD_CANCEL_BELOW ||
                       in_data.cmd == CMD_CANCEL_ALL || in_data.cmd == CMD_POP) begin
            state_nxt = (cnt_r != '0) ? ST_COPY : ST_FINAL;
          end
        end
      end

      // Walk from the tail: report superseded entries, note the eviction victim.
      ST_SCAN: begin
        if (superseded) begin
          if (can_emit) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{result_kind: RES_DROPPED, tag: ram_rdata.tag,
                        out_file_id: ram_rdata.file_id,
                        out_frame_number: ram_rdata.frame_number,
                        out_priority: ram_rdata.prio,
                        out_is_visible: ram_rdata.is_visible,
                        queue_count: 6'(cnt_r - 1'b1), last: 1'b0};
            cnt_nxt = cnt_r - 1'b1;
          end
        end else if (beaten && !evict_found_r) begin
          evict_found_nxt = 1'b1;
          evict_idx_nxt   = ridx_r;
          evict_ent_nxt   = ram_rdata;
        end
        if (!superseded || can_emit) begin
          if (ridx_r == '0) begin
            state_nxt = ST_DECIDE;
            rd_idx    = '0;
          end else begin
            rd_idx = ridx_r - 1'b1;
          end
          ridx_nxt = rd_idx;
        end
      end

      // Admission: reserve check, then eviction or refusal when the queue is full.
      ST_DECIDE: begin
        rd_idx   = '0;
        ridx_nxt = '0;
        if (!req_r.is_visible && (6'(cnt_r) >= limit)) begin
          accept_nxt = 1'b0;
          state_nxt  = (len_r != '0) ? ST_COPY : ST_FINAL;
        end else if (cnt_r == CW'(QUEUE_DEPTH)) begin
          if (!evict_found_r) begin
            accept_nxt = 1'b0;
            state_nxt  = ST_COPY;
          end else if (can_emit) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{result_kind: RES_DROPPED, tag: evict_ent_r.tag,
                        out_file_id: evict_ent_r.file_id,
                        out_frame_number: evict_ent_r.frame_number,
                        out_priority: evict_ent_r.prio,
                        out_is_visible: evict_ent_r.is_visible,
                        queue_count: 6'(cnt_r - 1'b1), last: 1'b0};
            cnt_nxt      = cnt_r - 1'b1;
            accept_nxt   = 1'b1;
            evict_on_nxt = 1'b1;
            state_nxt    = ST_COPY;
          end
        end else begin
          accept_nxt = 1'b1;
          state_nxt  = (len_r != '0) ? ST_COPY : ST_TAIL;
        end
      end

      // Stream the live bank into the other one, dropping and inserting.
      ST_COPY: begin
        logic advance;
        advance = 1'b1;
        if (req_r.cmd == CMD_SUBMIT && accept_r && !ins_done_r && !kill &&
            (ram_rdata.prio < req_r.priority_req)) begin
          ram_we       = 1'b1;
          ram_wdata    = req_ent;
          widx_nxt     = widx_r + 1'b1;
          ins_done_nxt = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          advance      = 1'b0;
        end else if (kill) begin
          if (req_r.cmd == CMD_POP) begin
            pop_ent_nxt = ram_rdata;
            cnt_nxt     = cnt_r - 1'b1;
          end else if (req_r.cmd != CMD_SUBMIT) begin
            if (can_emit) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{result_kind: RES_DROPPED, tag: ram_rdata.tag,
                          out_file_id: ram_rdata.file_id,
                          out_frame_number: ram_rdata.frame_number,
                          out_priority: ram_rdata.prio,
                          out_is_visible: ram_rdata.is_visible,
                          queue_count: 6'(cnt_r - 1'b1), last: 1'b0};
              cnt_nxt = cnt_r - 1'b1;
            end else begin
              advance = 1'b0;
            end
          end
        end else begin
          ram_we   = 1'b1;
          widx_nxt = widx_r + 1'b1;
        end
        if (advance) begin
          if (last_src) begin
            bank_nxt  = !bank_r;
            state_nxt = (req_r.cmd == CMD_SUBMIT && accept_r && !ins_done_r) ?
                        ST_TAIL : ST_FINAL;
          end else begin
            rd_idx = ridx_r + 1'b1;
          end
        end
        ridx_nxt = rd_idx;
      end

      // Request goes behind every kept entry.
      ST_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = {bank_r, widx_r[IW-1:0]};
        ram_wdata = req_ent;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_FINAL;
      end

      ST_FINAL: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_nxt = '0;
          out_nxt.queue_count = 6'(cnt_r);
          out_nxt.last = 1'b1;
          case (req_r.cmd)
            CMD_SUBMIT: begin
              out_nxt.result_kind      = accept_r ? RES_ACCEPTED : RES_REFUSED;
              out_nxt.tag              = accept_r ? tag_r : 32'd0;
              out_nxt.out_file_id      = req_r.file_id;
              out_nxt.out_frame_number = req_r.frame_number;
              out_nxt.out_priority     = req_r.priority_req;
              out_nxt.out_is_visible   = req_r.is_visible;
            end
            CMD_POP: begin
              if (len_r == '0) begin
                out_nxt.result_kind = RES_EMPTY;
              end else begin
                out_nxt.result_kind      = RES_DISPATCHED;
                out_nxt.tag              = pop_ent_r.tag;
                out_nxt.out_file_id      = pop_ent_r.file_id;
                out_nxt.out_frame_number = pop_ent_r.frame_number;
                out_nxt.out_priority     = pop_ent_r.prio;
                out_nxt.out_is_visible   = pop_ent_r.is_visible;
              end
            end
            default: begin
              out_nxt.result_kind = RES_CANCEL_DONE;
            end
          endcase
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    ram_raddr = {bank_nxt, rd_idx};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      next_tag_r  <= 32'd1;
      bank_r      <= 1'b0;
      reserve_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      next_tag_r  <= next_tag_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        reserve_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    tag_r         <= tag_nxt;
    len_r         <= len_nxt;
    ridx_r        <= ridx_nxt;
    widx_r        <= widx_nxt;
    ins_done_r    <= ins_done_nxt;
    accept_r      <= accept_nxt;
    evict_on_r    <= evict_on_nxt;
    evict_found_r <= evict_found_nxt;
    evict_idx_r   <= evict_idx_nxt;
    evict_ent_r   <= evict_ent_nxt;
    pop_ent_r     <= pop_ent_nxt;
    out_r         <= out_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
